### rtl/dio_pkg.sv
// ---------------------------------------------------------------------------
// Disk I/O timer register block - shared definitions
// Beat payload types, operation codes, bus address map and the wavetable
// memory request struct.
// ---------------------------------------------------------------------------
package dio_pkg;

   localparam int WAVE_DEPTH  = 64;
   localparam int WAVE_ADDR_W = $clog2(WAVE_DEPTH);
   localparam int WAVE_DATA_W = 6;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [15:0] ADDR_LATCH_LO = 16'h4020;
   localparam logic [15:0] ADDR_LATCH_HI = 16'h4021;
   localparam logic [15:0] ADDR_TIMER_CTL = 16'h4022;
   localparam logic [15:0] ADDR_IO_ENABLE = 16'h4023;
   localparam logic [15:0] ADDR_IRQ_ACK  = 16'h4024;
   localparam logic [15:0] ADDR_CONTROL  = 16'h4025;
   localparam logic [15:0] ADDR_STATUS   = 16'h4030;
   localparam logic [15:0] ADDR_DATA     = 16'h4031;
   localparam logic [15:0] ADDR_DISK     = 16'h4032;
   localparam logic [15:0] ADDR_EXT      = 16'h4033;
   localparam logic [15:0] ADDR_WAVE_WE  = 16'h4089;
   localparam logic [15:0] ADDR_OPEN_A   = 16'h4090;
   localparam logic [15:0] ADDR_OPEN_B   = 16'h4092;
   localparam logic [15:0] WAVE_BASE     = 16'h4040;
   localparam logic [15:0] WAVE_MASK     = 16'hffc0;

   localparam logic [2:0] DISK_STATUS_RESET = 3'd7;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  bus_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic       mirror_select;
   } rsp_payload_type;

   typedef struct packed {
      logic                   rd_en;
      logic                   wr_en;
      logic [WAVE_ADDR_W-1:0] addr;
      logic [WAVE_DATA_W-1:0] data;
   } wave_req_type;

endpackage

### rtl/disk_io_timer_register_block.sv
// ---------------------------------------------------------------------------
// Disk I/O timer register block
// Interval timer with interrupt, mirroring control and wavetable registers.
// ---------------------------------------------------------------------------
// Each req beat is a timer tick, a bus read or a bus write; each gives exactly
// one rsp beat carrying read data, the interrupt line level and the mirroring
// bit as they stand after that beat.
// Throughput: one beat per cycle while req_ready is high. Scalar registers and
// the wavetable read data update at the accepting edge; the merged result is
// written from stage register s1_ff into the output queue, and rsp_valid then rises.
// Results sit in a three-entry output queue. req_ready depends only on queue
// and stage occupancy, never combinationally on rsp_ready; when the receiver
// stalls, up to three results are held and then req_ready falls.
// The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the
// disk status register, with paddr not decoded; pready is tied high.
// Reset: synchronous, active high. Timer, flags and latch clear, disk status
// returns to 7, the wavetable reads as zero until written, queue empties.
// Writes to 0x4023 and the 0x4025 bits other than mirroring have no readback.
// ---------------------------------------------------------------------------
module disk_io_timer_register_block
   import dio_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [1:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam int QDEPTH = 3;

   typedef struct packed {
      logic       is_wave;
      logic [1:0] bus_hi;
      logic [7:0] base_data;
      logic       irq_line;
      logic       mirror_select;
   } stage_type;

   logic [2:0]  disk_status_ff;
   logic [15:0] timer_count_ff, timer_count_in;
   logic [15:0] timer_reload_ff, timer_reload_in;
   logic        timer_repeat_ff, timer_repeat_in;
   logic        timer_enable_ff, timer_enable_in;
   logic        mirror_bit_ff, mirror_bit_in;
   logic        pending_ff, pending_in;
   logic        line_ff, line_in;
   logic        wave_we_ff, wave_we_in;

   logic        s1_valid_ff;
   stage_type   s1_ff, s1_in;

   rsp_payload_type q_ff [QDEPTH];
   logic [1:0]  q_wr_ptr_ff, q_rd_ptr_ff, q_count_ff;
   logic [2:0]  occupancy;

   logic        accept, pop, in_wave;
   logic [15:0] count_dec;
   wave_req_type mem_req;
   logic [WAVE_DATA_W-1:0] wave_rd_data;
   rsp_payload_type s1_result;

   assign accept  = req_valid && req_ready;
   assign pop     = rsp_valid && rsp_ready;
   assign in_wave = (req_payload.address & WAVE_MASK) == WAVE_BASE;
   assign count_dec = timer_count_ff - 16'd1;

   assign occupancy = {1'b0, q_count_ff} + {2'b00, s1_valid_ff};
   assign req_ready = occupancy < 3'(QDEPTH);

   // ---- configuration port ----
   assign pready = 1'b1;
   assign prdata = {29'd0, disk_status_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_status_ff <= DISK_STATUS_RESET;
      end else if (psel && penable && pwrite) begin
         disk_status_ff <= pwdata[2:0];
      end
   end

   // ---- register update for the accepted beat ----
   always_comb begin
      timer_count_in  = timer_count_ff;
      timer_reload_in = timer_reload_ff;
      timer_repeat_in = timer_repeat_ff;
      timer_enable_in = timer_enable_ff;
      mirror_bit_in   = mirror_bit_ff;
      pending_in      = pending_ff;
      line_in         = line_ff;
      wave_we_in      = wave_we_ff;
      s1_in           = '0;
      s1_in.bus_hi    = req_payload.bus_data[7:6];

      case (req_payload.operation)
         OP_TICK: begin
            if (timer_enable_ff && timer_count_ff != 16'd0) begin
               timer_count_in = count_dec;
               if (count_dec == 16'd0) begin
                  line_in         = 1'b1;
                  pending_in      = 1'b1;
                  timer_reload_in = 16'd0;
                  if (timer_repeat_ff) begin
                     timer_count_in = timer_reload_ff;
                  end else begin
                     timer_enable_in = 1'b0;
                  end
               end
            end
         end
         OP_READ: begin
            if (in_wave) begin
               s1_in.is_wave = 1'b1;
            end else begin
               case (req_payload.address)
                  ADDR_STATUS: begin
                     s1_in.base_data = {7'd0, pending_ff};
                     pending_in      = 1'b0;
                     line_in         = 1'b0;
                  end
                  ADDR_DATA, ADDR_EXT: s1_in.base_data = 8'd0;
                  ADDR_DISK: s1_in.base_data = {5'd0, disk_status_ff};
                  ADDR_OPEN_A, ADDR_OPEN_B: begin
                     s1_in.base_data = {req_payload.bus_data[7:6], 6'd0};
                  end
                  default: s1_in.base_data = req_payload.bus_data;
               endcase
            end
         end
         OP_WRITE: begin
            case (req_payload.address)
               ADDR_LATCH_LO: timer_reload_in[7:0]  = req_payload.bus_data;
               ADDR_LATCH_HI: timer_reload_in[15:8] = req_payload.bus_data;
               ADDR_TIMER_CTL: begin
                  timer_repeat_in = req_payload.bus_data[0];
                  timer_enable_in = req_payload.bus_data[1];
                  timer_count_in  = timer_reload_ff;
                  line_in         = 1'b0;
               end
               ADDR_IRQ_ACK: line_in = 1'b0;
               ADDR_CONTROL: mirror_bit_in = req_payload.bus_data[3];
               ADDR_WAVE_WE: wave_we_in = req_payload.bus_data[7];
               default: ;
            endcase
         end
         default: ;
      endcase

      s1_in.irq_line      = line_in;
      s1_in.mirror_select = mirror_bit_in;
   end

   always_comb begin
      mem_req       = '0;
      mem_req.addr  = req_payload.address[WAVE_ADDR_W-1:0];
      mem_req.data  = req_payload.bus_data[WAVE_DATA_W-1:0];
      mem_req.rd_en = accept && req_payload.operation == OP_READ && in_wave;
      mem_req.wr_en = accept && req_payload.operation == OP_WRITE && in_wave && wave_we_ff;
   end

   dio_wave_mem u_wave_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (wave_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_count_ff  <= '0;
         timer_reload_ff <= '0;
         timer_repeat_ff <= 1'b0;
         timer_enable_ff <= 1'b0;
         mirror_bit_ff   <= 1'b0;
         pending_ff      <= 1'b0;
         line_ff         <= 1'b0;
         wave_we_ff      <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            timer_count_ff  <= timer_count_in;
            timer_reload_ff <= timer_reload_in;
            timer_repeat_ff <= timer_repeat_in;
            timer_enable_ff <= timer_enable_in;
            mirror_bit_ff   <= mirror_bit_in;
            pending_ff      <= pending_in;
            line_ff         <= line_in;
            wave_we_ff      <= wave_we_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ---- merge wavetable data, then queue ----
   always_comb begin
      s1_result.read_data     = s1_ff.is_wave ? {s1_ff.bus_hi, wave_rd_data}
                                              : s1_ff.base_data;
      s1_result.irq_line      = s1_ff.irq_line;
      s1_result.mirror_select = s1_ff.mirror_select;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_ff[q_wr_ptr_ff] <= s1_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         if (s1_valid_ff) begin
            q_wr_ptr_ff <= (q_wr_ptr_ff == 2'(QDEPTH - 1)) ? 2'd0 : q_wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            q_rd_ptr_ff <= (q_rd_ptr_ff == 2'(QDEPTH - 1)) ? 2'd0 : q_rd_ptr_ff + 2'd1;
         end
         q_count_ff <= q_count_ff + {1'b0, s1_valid_ff} - {1'b0, pop};
      end
   end

   assign rsp_valid   = q_count_ff != 2'd0;
   assign rsp_payload = q_ff[q_rd_ptr_ff];

   // ---- checks ----
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      occupancy <= 3'(QDEPTH))
      else $error("output queue overrun");

   a_status_clears_line: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.operation == OP_READ && req_payload.address == ADDR_STATUS)
      |=> (!line_ff && !pending_ff && !s1_ff.irq_line))
      else $error("status read left interrupt asserted");

   a_expiry_raises: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.operation == OP_TICK && timer_enable_ff
       && timer_count_ff == 16'd1)
      |=> (line_ff && pending_ff && timer_reload_ff == 16'd0))
      else $error("timer expiry did not raise interrupt");

   a_one_shot_stops: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.operation == OP_TICK && timer_enable_ff
       && !timer_repeat_ff && timer_count_ff == 16'd1)
      |=> (!timer_enable_ff && timer_count_ff == 16'd0))
      else $error("one-shot timer kept running");

   a_no_write_read_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("wavetable read and write in one beat");

endmodule

### rtl/dio_wave_mem.sv
// ---------------------------------------------------------------------------
// Wavetable memory
// 64 x 6 single-port-write / one-read memory with registered read data and
// per-entry valid flags so that unwritten entries read as zero after reset.
// ---------------------------------------------------------------------------
module dio_wave_mem
   import dio_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  wave_req_type           mem_req,
   output logic [WAVE_DATA_W-1:0] rd_data
);

   logic [WAVE_DATA_W-1:0] mem_ff [WAVE_DEPTH];
   logic [WAVE_DEPTH-1:0]  valid_ff;
   logic [WAVE_DATA_W-1:0] rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.addr] <= mem_req.data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.addr];
      end
   end

   // read-before-write on a shared edge is fine: one beat never both reads and writes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Disk I/O timer register block - testbench
// Drives ticks, bus reads and bus writes through the req channel and checks
// every rsp beat against a cycle-free model of the registers and wavetable.
// The disk status register is reprogrammed over APB between idle phases.
// Both channels idle at random, the receiver holds off once so that the block
// fills up, and the closing phase runs with no idling at all.
// ----------------------------------------------------------------------------
module testbench
   import dio_pkg::*;
();

   localparam logic [1:0] OP_NONE         = 2'd3;
   localparam logic [1:0] REG_DISK_STATUS = 2'd0;
   localparam int         PHASE_ITEMS     = 100;
   localparam int         HOLD_OFF_CYCLES = 120;
   localparam int         STALL_LIMIT     = 3000;

   class dio_scoreboard;
      logic [2:0]  disk_status;
      logic [15:0] tmr_count;
      logic [15:0] tmr_reload;
      logic        tmr_repeat;
      logic        tmr_enable;
      logic        disk_io_on;
      logic        sound_io_on;
      logic [7:0]  control_bits;
      logic        mirror;
      logic        pending;
      logic        irq_level;
      logic [5:0]  wave_ram [WAVE_DEPTH];
      logic        wave_we;
      rsp_payload_type predicted_rsp_q[$];
      int mismatches, rsp_checked, expiries, wave_writes;

      function new();
         disk_status  = DISK_STATUS_RESET;
         tmr_count    = '0;
         tmr_reload   = '0;
         tmr_repeat   = 1'b0;
         tmr_enable   = 1'b0;
         disk_io_on   = 1'b0;
         sound_io_on  = 1'b0;
         control_bits = 8'h26;
         mirror       = 1'b0;
         pending      = 1'b0;
         irq_level    = 1'b0;
         wave_we      = 1'b0;
         foreach (wave_ram[i]) wave_ram[i] = '0;
         mismatches   = 0;
         rsp_checked  = 0;
         expiries     = 0;
         wave_writes  = 0;
      endfunction

      function void set_disk_status(logic [2:0] v);
         disk_status = v;
      endfunction

      function int outstanding();
         return predicted_rsp_q.size();
      endfunction

      // Work out the rsp beat caused by an accepted req beat.
      function void note_request(req_payload_type r);
         rsp_payload_type e;
         logic [7:0]  rd;
         logic [15:0] a;
         logic [7:0]  d;
         rd = 8'h00;
         a  = r.address;
         d  = r.bus_data;
         case (r.operation)
            OP_TICK: begin
               if (tmr_enable && tmr_count != 16'd0) begin
                  tmr_count = tmr_count - 16'd1;
                  if (tmr_count == 16'd0) begin
                     irq_level = 1'b1;
                     pending   = 1'b1;
                     if (tmr_repeat) tmr_count = tmr_reload;
                     else tmr_enable = 1'b0;
                     tmr_reload = '0;
                     expiries++;
                  end
               end
            end
            OP_READ: begin
               if ((a & WAVE_MASK) == WAVE_BASE) begin
                  rd = {d[7:6], wave_ram[a[5:0]]};
               end else begin
                  case (a)
                     ADDR_STATUS: begin
                        rd        = {7'd0, pending};
                        pending   = 1'b0;
                        irq_level = 1'b0;
                     end
                     ADDR_DATA:                rd = 8'h00;
                     ADDR_DISK:                rd = {5'd0, disk_status};
                     ADDR_EXT:                 rd = 8'h00;
                     ADDR_OPEN_A, ADDR_OPEN_B: rd = d & 8'hc0;
                     default:                  rd = d;
                  endcase
               end
            end
            OP_WRITE: begin
               case (a)
                  ADDR_LATCH_LO: tmr_reload[7:0]  = d;
                  ADDR_LATCH_HI: tmr_reload[15:8] = d;
                  ADDR_TIMER_CTL: begin
                     tmr_repeat = d[0];
                     tmr_enable = d[1];
                     tmr_count  = tmr_reload;
                     irq_level  = 1'b0;
                  end
                  ADDR_IO_ENABLE: begin
                     disk_io_on  = d[0];
                     sound_io_on = d[1];
                  end
                  ADDR_IRQ_ACK: irq_level = 1'b0;
                  ADDR_CONTROL: begin
                     control_bits = d & 8'hf7;
                     mirror       = d[3];
                  end
                  ADDR_WAVE_WE: wave_we = d[7];
                  default: ;
               endcase
               if ((a & WAVE_MASK) == WAVE_BASE && wave_we) begin
                  wave_ram[a[5:0]] = d[5:0];
                  wave_writes++;
               end
            end
            default: ;
         endcase
         e.read_data     = rd;
         e.irq_line      = irq_level;
         e.mirror_select = mirror;
         predicted_rsp_q.push_back(e);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type e;
         rsp_checked++;
         if (predicted_rsp_q.size() == 0) begin
            $display("%0t: rsp beat with nothing predicted, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         e = predicted_rsp_q.pop_front();
         if (got.read_data !== e.read_data) begin
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, e.read_data, got.read_data);
            mismatches++;
         end
         if (got.irq_line !== e.irq_line) begin
            $display("%0t: irq_line mismatch, expected %b, actual %b",
                     $time, e.irq_line, got.irq_line);
            mismatches++;
         end
         if (got.mirror_select !== e.mirror_select) begin
            $display("%0t: mirror_select mismatch, expected %b, actual %b",
                     $time, e.mirror_select, got.mirror_select);
            mismatches++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [1:0]      paddr;
   logic [31:0]     pwdata;
   logic [31:0]     prdata;
   logic            pready;

   dio_scoreboard sb = new();
   bit  quiet_phase;
   bit  hold_off_due;
   int  items_sent;
   int  stall_cycles;

   disk_io_timer_register_block DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic req_payload_type beat(logic [1:0] op, logic [15:0] a, logic [7:0] d);
      req_payload_type r;
      r.operation = op;
      r.address   = a;
      r.bus_data  = d;
      return r;
   endfunction

   function automatic int pick_gap();
      if (quiet_phase || $urandom_range(0, 9) > 2) return 0;
      return $urandom_range(1, 12);
   endfunction

   // Offer one req beat, idling first for gap cycles, and return at the
   // accepting edge.
   task automatic send_beat(req_payload_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_DISK_STATUS;
      pwdata  <= {29'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_disk_status(v);
   endtask

   // Random beat, weighted towards mapped registers and short timer periods
   // so that expiries and status reads turn up often.
   task automatic send_random_beat();
      logic [15:0] reg_map [14];
      int          sel;
      logic [1:0]  op;
      logic [15:0] a;
      logic [7:0]  d;
      reg_map = '{ADDR_LATCH_LO, ADDR_LATCH_HI, ADDR_TIMER_CTL, ADDR_IO_ENABLE,
                  ADDR_IRQ_ACK, ADDR_CONTROL, ADDR_STATUS, ADDR_DATA, ADDR_DISK,
                  ADDR_EXT, ADDR_WAVE_WE, ADDR_OPEN_A, ADDR_OPEN_B, ADDR_STATUS};
      sel = $urandom_range(0, 99);
      if (sel < 35)      op = OP_TICK;
      else if (sel < 60) op = OP_READ;
      else if (sel < 97) op = OP_WRITE;
      else               op = OP_NONE;
      sel = $urandom_range(0, 9);
      if (sel < 6)       a = reg_map[$urandom_range(0, 13)];
      else if (sel < 8)  a = WAVE_BASE + 16'($urandom_range(0, WAVE_DEPTH - 1));
      else if (sel == 8) a = 16'($urandom);
      else               a = 16'h4000 + 16'($urandom_range(0, 255));
      d = 8'($urandom);
      if (op == OP_WRITE && a == ADDR_LATCH_HI && $urandom_range(0, 3) != 0)
         d = 8'h00;
      if (op == OP_WRITE && a == ADDR_LATCH_LO && $urandom_range(0, 9) < 7)
         d = 8'($urandom_range(1, 8));
      send_beat(beat(op, a, d));
   endtask

   // Receiver: random stalls, one long hold-off, none in the closing phase.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (quiet_phase) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 4) == 0 ? 60 : $urandom_range(1, 20))
               @(posedge clock);
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [2:0] disk_settings [8];
      disk_settings = '{3'd0, 3'd7, 3'd5, 3'd2, 3'd1, 3'd6, 3'd4, 3'd3};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      quiet_phase  = 1'b0;
      hold_off_due = 1'b0;
      items_sent   = 0;
      stall_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: timer edge cases, every register but DATA and EXT, wave access, open bus.
      send_beat(beat(OP_TICK,  16'h0000,       8'hff));   // disabled timer
      send_beat(beat(OP_WRITE, ADDR_LATCH_LO,  8'h03));
      send_beat(beat(OP_WRITE, ADDR_TIMER_CTL, 8'h03));   // repeat + enable
      repeat (3) send_beat(beat(OP_TICK, 16'hffff, 8'h00));
      send_beat(beat(OP_READ,  ADDR_STATUS,    8'hff));   // pending, then cleared
      send_beat(beat(OP_TICK,  16'h0000,       8'h00));   // counter was reloaded before the latch cleared
      send_beat(beat(OP_WRITE, ADDR_LATCH_LO,  8'h01));
      send_beat(beat(OP_WRITE, ADDR_LATCH_HI,  8'h00));
      send_beat(beat(OP_WRITE, ADDR_TIMER_CTL, 8'h02));   // one-shot
      send_beat(beat(OP_TICK,  16'h0000,       8'h00));
      send_beat(beat(OP_WRITE, ADDR_IRQ_ACK,   8'h00));
      send_beat(beat(OP_WRITE, ADDR_IO_ENABLE, 8'h03));
      send_beat(beat(OP_WRITE, ADDR_CONTROL,   8'hff));
      send_beat(beat(OP_WRITE, ADDR_WAVE_WE,   8'h80));
      send_beat(beat(OP_WRITE, 16'h4040,       8'hff));
      send_beat(beat(OP_WRITE, 16'h407f,       8'h2a));
      send_beat(beat(OP_READ,  16'h4040,       8'hff));
      send_beat(beat(OP_READ,  16'h407f,       8'h00));
      send_beat(beat(OP_READ,  ADDR_DISK,      8'h00));
      send_beat(beat(OP_READ,  ADDR_OPEN_A,    8'hff));
      send_beat(beat(OP_READ,  ADDR_OPEN_B,    8'h3f));
      send_beat(beat(OP_READ,  16'hffff,       8'ha5));   // unmapped: open bus
      send_beat(beat(OP_NONE,  16'hffff,       8'hff));
      send_beat(beat(OP_WRITE, ADDR_WAVE_WE,   8'h7f));
      send_beat(beat(OP_WRITE, 16'h4041,       8'h15));   // wave write locked
      send_beat(beat(OP_READ,  16'h4041,       8'hc0));
      send_beat(beat(OP_WRITE, ADDR_CONTROL,   8'h00));
      drain();

      foreach (disk_settings[p]) begin
         csr_write(disk_settings[p]);
         if (p == 1) hold_off_due = 1'b1;
         if (p == 7) quiet_phase = 1'b1;
         repeat (PHASE_ITEMS) send_random_beat();
         drain();
      end

      $display("Sent %0d req beats over 9 phases, checked %0d rsp beats.",
               items_sent, sb.rsp_checked);
      $display("Timer expired %0d times, %0d wavetable entries written.",
               sb.expiries, sb.wave_writes);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### disk_io_timer_register_block.f
rtl/dio_pkg.sv
rtl/dio_wave_mem.sv
rtl/disk_io_timer_register_block.sv
verif/testbench.sv
